// File: hw/rtl/dssm_pkg.sv
// Shared types and constants for the dual stack shared memory core.
package dssm_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;  // func + push_value = 35 bits, padded to bytes
  localparam int OUT_TDATA_W = 40;  // read_value + status + two flags = 36 bits, padded

  localparam logic [FUNC_W-1:0] FN_PUSH1 = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH2 = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP1  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP2  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK1 = 3'd4;
  localparam logic [FUNC_W-1:0] FN_PEEK2 = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Everything about a result that is known at request time
  typedef struct packed {
    logic                use_ram;
    logic [DATA_W-1:0]   rd_const;
    logic [STATUS_W-1:0] status;
    logic                first_empty;
    logic                second_empty;
  } res_meta_t;

endpackage

// File: hw/rtl/dssm_ram.sv
// Generic single-port synchronous RAM with registered read.
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hw/rtl/dssm_ctrl.sv
// Stack pointer control: decodes a request, updates both counts, drives the RAM port.
module dssm_ctrl #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  logic [dssm_pkg::FUNC_W-1:0]   func,
  input  logic [dssm_pkg::DATA_W-1:0]   push_value,
  output logic                          mem_en,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_addr,
  output logic [dssm_pkg::DATA_W-1:0]   mem_wdata,
  output dssm_pkg::res_meta_t           meta
);

  logic [CW-1:0] cnt1_r, cnt1_nxt;
  logic [CW-1:0] cnt2_r, cnt2_nxt;
  logic [CW:0]   used;
  logic          has_room;
  logic [CW-1:0] top1_addr, top2_addr, push2_addr;

  assign used       = {1'b0, cnt1_r} + {1'b0, cnt2_r};
  assign has_room   = used < (CW + 1)'(DEPTH);
  assign top1_addr  = cnt1_r - CW'(1);
  assign top2_addr  = CW'(DEPTH) - cnt2_r;
  assign push2_addr = CW'(DEPTH - 1) - cnt2_r;
  assign mem_wdata  = push_value;

  always_comb begin
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = '0;
    meta.use_ram  = 1'b0;
    meta.rd_const = '0;
    meta.status   = dssm_pkg::ST_OK;
    unique case (func)
      dssm_pkg::FN_PUSH1, dssm_pkg::FN_PUSH2: begin
        if (has_room) begin
          mem_en = req_valid;
          mem_we = 1'b1;
          if (func == dssm_pkg::FN_PUSH1) begin
            mem_addr = cnt1_r[AW-1:0];
            cnt1_nxt = cnt1_r + CW'(1);
          end else begin
            mem_addr = push2_addr[AW-1:0];
            cnt2_nxt = cnt2_r + CW'(1);
          end
        end else begin
          meta.status = dssm_pkg::ST_OVERFLOW;
        end
      end
      dssm_pkg::FN_POP1, dssm_pkg::FN_PEEK1: begin
        if (cnt1_r != '0) begin
          mem_en       = req_valid;
          mem_addr     = top1_addr[AW-1:0];
          meta.use_ram = 1'b1;
          if (func == dssm_pkg::FN_POP1) begin
            cnt1_nxt = top1_addr;
          end
        end else begin
          meta.rd_const = '1;
          meta.status   = dssm_pkg::ST_UNDERFLOW;
        end
      end
      dssm_pkg::FN_POP2, dssm_pkg::FN_PEEK2: begin
        if (cnt2_r != '0) begin
          mem_en       = req_valid;
          mem_addr     = top2_addr[AW-1:0];
          meta.use_ram = 1'b1;
          if (func == dssm_pkg::FN_POP2) begin
            cnt2_nxt = cnt2_r - CW'(1);
          end
        end else begin
          meta.rd_const = '1;
          meta.status   = dssm_pkg::ST_UNDERFLOW;
        end
      end
      default: ;  // unused codes leave state alone
    endcase
    meta.first_empty  = (cnt1_nxt == '0);
    meta.second_empty = (cnt2_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r <= '0;
      cnt2_r <= '0;
    end else if (req_valid) begin
      cnt1_r <= cnt1_nxt;
      cnt2_r <= cnt2_nxt;
    end
  end

endmodule

// File: hw/rtl/dual_stack_shared_memory_core.sv
// Top level: two stacks in one RAM, request stream in, result stream out.
//
// Usage:
//   in_tdata carries one request: func (push/pop/peek on stack one or two)
//   and push_value. Stack one grows up from word 0, stack two down from
//   word DEPTH-1. Each request gives exactly one result on out_tdata:
//   read_value, status (ok, overflow, underflow) and both empty flags.
// Result path: a taken request passes the RAM read register (with its
//   result fields held in pend_meta_r) and then the output register.
// Flow: in_tready is low while a request's result is pending; the RAM read
//   issued for a pop or peek must return before the next request is decoded.
// Reset: both stacks become empty; RAM contents are not cleared and are
//   never read before being written. Output and holding stages empty.
// Stall: a result waiting on out_tready stays put; one further request is
//   taken and its result parked in a holding register, after which
//   in_tready stays low until the output drains.
module dual_stack_shared_memory_core #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] func, [34:3] push_value, [39:35] zero
  input  logic [dssm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] read_value, [33:32] status, [34] first_empty, [35] second_empty,
  // [39:36] zero
  output logic [dssm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = dssm_pkg::DATA_W;
  localparam int OW = dssm_pkg::OUT_TDATA_W;
  localparam int FW = dssm_pkg::FUNC_W;

  logic                in_acc;
  logic                mem_en, mem_we;
  logic [AW-1:0]       mem_addr;
  logic [DW-1:0]       mem_wdata, mem_rdata;
  dssm_pkg::res_meta_t meta;

  logic                rd_pend_r, rd_pend_nxt;
  dssm_pkg::res_meta_t pend_meta_r;
  logic                hold_valid_r, hold_valid_nxt;
  logic [OW-1:0]       hold_data_r, hold_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OW-1:0]       out_data_r, out_data_nxt;
  logic [OW-1:0]       res_word;
  logic                out_free;

  assign in_tready = !rd_pend_r && !hold_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  dssm_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_acc),
    .func       (in_tdata[FW-1:0]),
    .push_value (in_tdata[FW+DW-1:FW]),
    .mem_en     (mem_en),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .meta       (meta)
  );

  dssm_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // RAM data is only live the cycle after the read
  assign res_word = {(OW - DW - dssm_pkg::STATUS_W - 2)'(0),
                     pend_meta_r.second_empty, pend_meta_r.first_empty,
                     pend_meta_r.status,
                     pend_meta_r.use_ram ? mem_rdata : pend_meta_r.rd_const};

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    rd_pend_nxt    = in_acc;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_free) begin
      out_valid_nxt = hold_valid_r || rd_pend_r;
      if (hold_valid_r) begin
        out_data_nxt   = hold_data_r;
        hold_valid_nxt = 1'b0;
      end else if (rd_pend_r) begin
        out_data_nxt = res_word;
      end
    end else if (rd_pend_r) begin
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r    <= rd_pend_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_meta_r <= meta;
    end
    hold_data_r <= hold_data_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
